@@ hw/rtl/cfa_pkg.sv @@
`timescale 1ns / 1ps

package cfa_pkg;

    // Operation codes as they arrive on req_type.
    typedef enum logic [2:0]
    {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_CONJ  = 3'd4,
        OP_SQMAG = 3'd5
    } op_t;

    // Datapath class that the front end assigns to each request.
    typedef enum logic [2:0]
    {
        K_NONE   = 3'd0,
        K_ADDSUB = 3'd1,
        K_MUL    = 3'd2,
        K_DIV    = 3'd3,
        K_CONJ   = 3'd4,
        K_MAG    = 3'd5
    } kind_t;

    typedef struct packed
    {
        kind_t kind;
        logic  sub;
    } cls_t;

    localparam int QDEPTH = 4;

endpackage

@@ hw/rtl/cfa_queue.sv @@
`timescale 1ns / 1ps

module cfa_queue #(
    parameter int WIDTH = 132
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTRW = $clog2(cfa_pkg::QDEPTH);
    localparam int CNTW = $clog2(cfa_pkg::QDEPTH + 1);

    logic [WIDTH-1:0] mem_reg [cfa_pkg::QDEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic [CNTW-1:0]  cnt_next;

    assign full  = (cnt_reg == CNTW'(cfa_pkg::QDEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ hw/rtl/cfa_front.sv @@
`timescale 1ns / 1ps

module cfa_front #(
    parameter int W = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           req_type,
    input  logic signed [W-1:0]  a_re,
    input  logic signed [W-1:0]  a_im,
    input  logic signed [W-1:0]  b_re,
    input  logic signed [W-1:0]  b_im,
    input  logic                 pop,
    output logic                 q_valid,
    output logic [$bits(cfa_pkg::cls_t)+4*W-1:0] q_data
);

    localparam int EW = $bits(cfa_pkg::cls_t) + 4 * W;

    cfa_pkg::cls_t cls;
    logic          full;
    logic          empty;
    logic          push;

    always_comb
    begin
        cls.kind = cfa_pkg::K_NONE;
        cls.sub  = 1'b0;
        case (cfa_pkg::op_t'(req_type))
            cfa_pkg::OP_ADD:   cls.kind = cfa_pkg::K_ADDSUB;
            cfa_pkg::OP_SUB:
            begin
                cls.kind = cfa_pkg::K_ADDSUB;
                cls.sub  = 1'b1;
            end
            cfa_pkg::OP_MUL:   cls.kind = cfa_pkg::K_MUL;
            cfa_pkg::OP_DIV:   cls.kind = cfa_pkg::K_DIV;
            cfa_pkg::OP_CONJ:  cls.kind = cfa_pkg::K_CONJ;
            cfa_pkg::OP_SQMAG: cls.kind = cfa_pkg::K_MAG;
            default:           cls.kind = cfa_pkg::K_NONE;
        endcase
    end

    assign push    = start && !full;
    assign busy    = full;
    assign q_valid = !empty;

    cfa_queue #(
        .WIDTH(EW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({cls, a_re, a_im, b_re, b_im}),
        .pop   (pop),
        .rdata (q_data),
        .full  (full),
        .empty (empty)
    );

endmodule

@@ hw/rtl/cfa_div.sv @@
`timescale 1ns / 1ps

module cfa_div #(
    parameter int NW = 82,
    parameter int DW = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num_re,
    input  logic [NW-1:0] num_im,
    input  logic          neg_re,
    input  logic          neg_im,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic          done,
    output logic [NW-1:0] q_re,
    output logic [NW-1:0] q_im,
    output logic          q_neg_re,
    output logic          q_neg_im
);

    localparam int CNTW = $clog2(NW + 1);

    logic            run_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [NW-1:0]   nre_reg;
    logic [NW-1:0]   nim_reg;
    logic [NW-1:0]   qre_reg;
    logic [NW-1:0]   qim_reg;
    logic [DW-1:0]   rre_reg;
    logic [DW-1:0]   rim_reg;
    logic [DW-1:0]   den_reg;
    logic            sre_reg;
    logic            sim_reg;
    logic [DW:0]     st_re;
    logic [DW:0]     st_im;

    // One restoring step: returns the quotient bit above the new remainder.
    function automatic logic [DW:0] div_step(input logic [DW-1:0] r, input logic b,
                                             input logic [DW-1:0] d);
        logic [DW:0] r2;
        logic [DW:0] diff;
        r2   = {r, b};
        diff = r2 - {1'b0, d};
        if (r2 >= {1'b0, d})
        begin
            return {1'b1, diff[DW-1:0]};
        end
        return {1'b0, r2[DW-1:0]};
    endfunction

    assign st_re    = div_step(rre_reg, nre_reg[NW-1], den_reg);
    assign st_im    = div_step(rim_reg, nim_reg[NW-1], den_reg);
    assign busy     = run_reg || done_reg;
    assign done     = done_reg;
    assign q_re     = qre_reg;
    assign q_im     = qim_reg;
    assign q_neg_re = sre_reg;
    assign q_neg_im = sim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNTW'(NW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nre_reg <= num_re;
            nim_reg <= num_im;
            qre_reg <= '0;
            qim_reg <= '0;
            rre_reg <= '0;
            rim_reg <= '0;
            den_reg <= den;
            sre_reg <= neg_re;
            sim_reg <= neg_im;
        end
        else if (run_reg)
        begin
            nre_reg <= {nre_reg[NW-2:0], 1'b0};
            nim_reg <= {nim_reg[NW-2:0], 1'b0};
            qre_reg <= {qre_reg[NW-2:0], st_re[DW]};
            qim_reg <= {qim_reg[NW-2:0], st_im[DW]};
            rre_reg <= st_re[DW-1:0];
            rim_reg <= st_im[DW-1:0];
        end
    end

endmodule

@@ hw/rtl/cfa_back.sv @@
`timescale 1ns / 1ps

module cfa_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  logic [$bits(cfa_pkg::cls_t)+4*W-1:0] q_data,
    output logic                 q_pop,
    input  logic [W-2:0]         thr,
    output logic                 res_valid,
    output logic signed [W-1:0]  res_re,
    output logic signed [W-1:0]  res_im,
    output logic                 is_complex,
    output logic                 div_zero,
    output logic                 saturated
);

    localparam int CW = $bits(cfa_pkg::cls_t);
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam int QW = SW + F;

    cfa_pkg::cls_t      q_cls;
    logic signed [W-1:0] q_ar, q_ai, q_br, q_bi;
    logic               stall;

    // Stage 1: products.
    logic                s1_valid_reg;
    cfa_pkg::cls_t       s1_cls_reg;
    logic signed [W-1:0] s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;
    logic signed [PW-1:0] m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic signed [W-1:0] my0, my1;

    // Stage 2: exact sums.
    logic                s2_valid_reg;
    logic signed [SW-1:0] s2_vre_reg, s2_vim_reg;
    logic                s2_shf_reg, s2_dz_reg, s2_dv_reg;
    logic [PW-1:0]       s2_den_reg;
    logic signed [SW-1:0] vre, vim;
    logic                shf, dz, dv;
    logic [PW-1:0]       den;

    // Stage 3: sign and magnitude.
    logic                s3_valid_reg;
    logic [SW-1:0]       s3_mre_reg, s3_mim_reg;
    logic                s3_nre_reg, s3_nim_reg, s3_dz_reg, s3_dv_reg;
    logic [PW-1:0]       s3_den_reg;
    logic [SW-1:0]       are, aim, mre, mim;

    // Divider.
    logic                div_start, div_busy, div_done;
    logic [QW-1:0]       dq_re, dq_im;
    logic                dq_nre, dq_nim;

    // Output selection.
    logic                sel_valid;
    logic [QW-1:0]       o_mre, o_mim;
    logic                o_nre, o_nim, o_dz;
    logic [W:0]          c_re, c_im;

    logic                res_valid_reg;
    logic [W-1:0]        res_re_reg, res_im_reg;
    logic                is_complex_reg, div_zero_reg, saturated_reg;

    function automatic logic signed [SW-1:0] sx_w(input logic signed [W-1:0] x);
        return SW'(x);
    endfunction

    function automatic logic signed [SW-1:0] sx_p(input logic signed [PW-1:0] x);
        return SW'(x);
    endfunction

    // Clip a magnitude to the word range; returns {clipped, clipped magnitude}.
    function automatic logic [W:0] clamp(input logic neg, input logic [QW-1:0] m);
        logic [W-1:0] lim;
        logic         over;
        lim  = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        over = (m > QW'(lim));
        return {over, over ? lim : m[W-1:0]};
    endfunction

    assign q_cls = cfa_pkg::cls_t'(q_data[CW+4*W-1 -: CW]);
    assign q_ar  = q_data[4*W-1 -: W];
    assign q_ai  = q_data[3*W-1 -: W];
    assign q_br  = q_data[2*W-1 -: W];
    assign q_bi  = q_data[W-1:0];

    // The whole pipe holds while the divider owns the back end.
    assign stall = div_busy;
    assign q_pop = q_valid && !stall;

    assign my0 = (q_cls.kind == cfa_pkg::K_MAG) ? q_ar : q_br;
    assign my1 = (q_cls.kind == cfa_pkg::K_MAG) ? q_ai : q_bi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!stall)
            begin
                s1_valid_reg <= q_pop;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
            res_valid_reg <= sel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s1_cls_reg <= q_cls;
            s1_ar_reg  <= q_ar;
            s1_ai_reg  <= q_ai;
            s1_br_reg  <= q_br;
            s1_bi_reg  <= q_bi;
            m0_reg     <= q_ar * my0;
            m1_reg     <= q_ai * my1;
            m2_reg     <= q_ar * q_bi;
            m3_reg     <= q_ai * q_br;
            m4_reg     <= q_br * q_br;
            m5_reg     <= q_bi * q_bi;

            s2_vre_reg <= vre;
            s2_vim_reg <= vim;
            s2_shf_reg <= shf;
            s2_dz_reg  <= dz;
            s2_dv_reg  <= dv;
            s2_den_reg <= den;

            s3_mre_reg <= mre;
            s3_mim_reg <= mim;
            s3_nre_reg <= s2_vre_reg[SW-1];
            s3_nim_reg <= s2_vim_reg[SW-1];
            s3_dz_reg  <= s2_dz_reg;
            s3_dv_reg  <= s2_dv_reg;
            s3_den_reg <= s2_den_reg;
        end
        if (sel_valid)
        begin
            res_re_reg     <= o_nre ? -c_re[W-1:0] : c_re[W-1:0];
            res_im_reg     <= o_nim ? -c_im[W-1:0] : c_im[W-1:0];
            is_complex_reg <= (c_im[W-1:0] > {1'b0, thr});
            div_zero_reg   <= o_dz;
            saturated_reg  <= c_re[W] || c_im[W];
        end
    end

    always_comb
    begin
        vre = '0;
        vim = '0;
        shf = 1'b0;
        dz  = 1'b0;
        dv  = 1'b0;
        den = PW'($unsigned(m4_reg)) + PW'($unsigned(m5_reg));
        case (s1_cls_reg.kind)
            cfa_pkg::K_ADDSUB:
            begin
                vre = s1_cls_reg.sub ? sx_w(s1_ar_reg) - sx_w(s1_br_reg)
                                     : sx_w(s1_ar_reg) + sx_w(s1_br_reg);
                vim = s1_cls_reg.sub ? sx_w(s1_ai_reg) - sx_w(s1_bi_reg)
                                     : sx_w(s1_ai_reg) + sx_w(s1_bi_reg);
            end
            cfa_pkg::K_MUL:
            begin
                vre = sx_p(m0_reg) - sx_p(m1_reg);
                vim = sx_p(m2_reg) + sx_p(m3_reg);
                shf = 1'b1;
            end
            cfa_pkg::K_DIV:
            begin
                // A zero divisor passes a through; its nonzero parts clip below.
                if (s1_br_reg == '0 && s1_bi_reg == '0)
                begin
                    dz  = 1'b1;
                    vre = sx_w(s1_ar_reg);
                    vim = sx_w(s1_ai_reg);
                end
                else
                begin
                    dv  = 1'b1;
                    vre = sx_p(m0_reg) + sx_p(m1_reg);
                    vim = sx_p(m3_reg) - sx_p(m2_reg);
                end
            end
            cfa_pkg::K_CONJ:
            begin
                vre = sx_w(s1_ar_reg);
                vim = -sx_w(s1_ai_reg);
            end
            cfa_pkg::K_MAG:
            begin
                vre = sx_p(m0_reg) + sx_p(m1_reg);
                shf = 1'b1;
            end
            default:
            begin
                vre = '0;
                vim = '0;
            end
        endcase
    end

    // Truncation toward zero is a shift of the magnitude.
    always_comb
    begin
        are = s2_vre_reg[SW-1] ? SW'(-s2_vre_reg) : SW'(s2_vre_reg);
        aim = s2_vim_reg[SW-1] ? SW'(-s2_vim_reg) : SW'(s2_vim_reg);
        if (s2_dz_reg)
        begin
            mre = (s2_vre_reg != '0) ? '1 : '0;
            mim = (s2_vim_reg != '0) ? '1 : '0;
        end
        else if (s2_shf_reg)
        begin
            mre = are >> F;
            mim = aim >> F;
        end
        else
        begin
            mre = are;
            mim = aim;
        end
    end

    assign div_start = s3_valid_reg && s3_dv_reg && !stall;

    cfa_div #(
        .NW(QW),
        .DW(PW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num_re   (QW'(s3_mre_reg) << F),
        .num_im   (QW'(s3_mim_reg) << F),
        .neg_re   (s3_nre_reg),
        .neg_im   (s3_nim_reg),
        .den      (s3_den_reg),
        .busy     (div_busy),
        .done     (div_done),
        .q_re     (dq_re),
        .q_im     (dq_im),
        .q_neg_re (dq_nre),
        .q_neg_im (dq_nim)
    );

    always_comb
    begin
        if (div_done)
        begin
            sel_valid = 1'b1;
            o_mre     = dq_re;
            o_mim     = dq_im;
            o_nre     = dq_nre;
            o_nim     = dq_nim;
            o_dz      = 1'b0;
        end
        else
        begin
            sel_valid = s3_valid_reg && !s3_dv_reg && !stall;
            o_mre     = QW'(s3_mre_reg);
            o_mim     = QW'(s3_mim_reg);
            o_nre     = s3_nre_reg;
            o_nim     = s3_nim_reg;
            o_dz      = s3_dz_reg;
        end
        c_re = clamp(o_nre, o_mre);
        c_im = clamp(o_nim, o_mim);
    end

    assign res_valid  = res_valid_reg;
    assign res_re     = res_re_reg;
    assign res_im     = res_im_reg;
    assign is_complex = is_complex_reg;
    assign div_zero   = div_zero_reg;
    assign saturated  = saturated_reg;

endmodule

@@ hw/rtl/complex_fixed_point_alu_core.sv @@
`timescale 1ns / 1ps

// Complex fixed-point arithmetic unit: add, subtract, multiply, divide, conjugate and
// squared magnitude on signed Q(WORD_BITS-FRAC_BITS).FRAC_BITS operands. A request
// transfers when start is high and busy is low; busy rises only when the four-entry
// request queue is full. Results come back in request order, each on the result
// ports for exactly one cycle with res_valid high, after the queue and the product,
// sum, magnitude and result registers. All operations except a divide with a nonzero
// divisor sustain one request per cycle through the multiply, sum, magnitude and
// output stages while the divider is idle. A divide with a nonzero divisor occupies
// the bit-serial restoring divider of the back end; while it runs, the back end holds
// and the queue absorbs new requests. The threshold register is written with
// cfg_we and should only change while no request is in flight.
module complex_fixed_point_alu_core #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  req_type,
    input  logic signed [WORD_BITS-1:0] a_re,
    input  logic signed [WORD_BITS-1:0] a_im,
    input  logic signed [WORD_BITS-1:0] b_re,
    input  logic signed [WORD_BITS-1:0] b_im,
    input  logic                        cfg_we,
    input  logic [WORD_BITS-2:0]        cfg_wdata,
    output logic                        res_valid,
    output logic signed [WORD_BITS-1:0] res_re,
    output logic signed [WORD_BITS-1:0] res_im,
    output logic                        is_complex,
    output logic                        div_zero,
    output logic                        saturated
);

    localparam int EW = $bits(cfa_pkg::cls_t) + 4 * WORD_BITS;

    logic [WORD_BITS-2:0] thr_reg;
    logic                 q_valid;
    logic                 q_pop;
    logic [EW-1:0]        q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    cfa_front #(
        .W(WORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_data   (q_data)
    );

    cfa_back #(
        .W(WORD_BITS),
        .F(FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .thr        (thr_reg),
        .res_valid  (res_valid),
        .res_re     (res_re),
        .res_im     (res_im),
        .is_complex (is_complex),
        .div_zero   (div_zero),
        .saturated  (saturated)
    );

endmodule

@@ hw/rtl/cfa_checker.sv @@
`timescale 1ns / 1ps

module cfa_checker #(
    parameter int WORD_BITS = 32
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 res_valid,
    input logic [WORD_BITS-1:0] res_re,
    input logic [WORD_BITS-1:0] res_im,
    input logic                 is_complex,
    input logic                 div_zero,
    input logic                 saturated
);

    // The queue can only fill through a transfer in the cycle before.
    a_busy_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // The threshold is never negative, so a complex result has a nonzero imaginary part.
    a_complex_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && is_complex) |-> (res_im != '0))
        else $error("is_complex set on a zero imaginary part");

    // On a zero divisor every nonzero part is clipped and every zero part stays zero.
    a_dz_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && div_zero) |-> (saturated == ((res_re != '0) || (res_im != '0))))
        else $error("division by zero flags disagree with result");

endmodule

bind complex_fixed_point_alu_core cfa_checker #(
    .WORD_BITS(WORD_BITS)
) u_cfa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .res_valid  (res_valid),
    .res_re     (res_re),
    .res_im     (res_im),
    .is_complex (is_complex),
    .div_zero   (div_zero),
    .saturated  (saturated)
);
